/* sv/mrf_pkg.sv */
package mrf_pkg;

    localparam int ADDR_W            = 48;
    localparam int TIME_W            = 32;
    localparam int WIN_W             = 16;
    localparam int DEF_TABLE_ENTRIES = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10000;

    typedef enum logic [1:0] {
        OC_RECENT  = 2'd0,
        OC_REFRESH = 2'd1,
        OC_INSERT  = 2'd2,
        OC_REPLACE = 2'd3
    } t_outcome;

    // Query travelling down the row of cells.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              recent;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
    } t_token;

endpackage

/* sv/mrf_cell.sv */
module mrf_cell
    import mrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_token            i_tok,
    input  logic [WIN_W-1:0]  i_window,
    input  logic              i_in_use,
    input  logic              i_ins_en,
    input  logic [ADDR_W-1:0] i_ins_addr,
    input  logic [TIME_W-1:0] i_ins_time,
    output t_token            o_tok
);

    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_time;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;
    logic              w_recent;
    logic [TIME_W-1:0] w_age;

    // Only the first matching cell claims the query; later cells pass it on.
    always_comb begin
        w_match  = i_tok.valid && !i_tok.found && i_in_use && (r_addr == i_tok.addr);
        w_age    = i_tok.now - r_time;
        w_recent = w_age < {{(TIME_W-WIN_W){1'b0}}, i_window};
        n_tok    = i_tok;
        if (w_match) begin
            n_tok.found  = 1'b1;
            n_tok.recent = w_recent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found  <= n_tok.found;
        r_tok.recent <= n_tok.recent;
        r_tok.addr   <= n_tok.addr;
        r_tok.now    <= n_tok.now;
    end

    always_ff @(posedge i_clk) begin
        if (i_ins_en) begin
            r_addr <= i_ins_addr;
            r_time <= i_ins_time;
        end else if (w_match && !w_recent) begin
            r_time <= i_tok.now;
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/mac_rediscovery_filter.sv */
// Duplicate filter for device addresses with a time window.
// Input channel: i_in_valid / o_in_stall carry one beat of i_mac_address and
// i_now_ms. Output channel: o_out_valid / i_out_stall carry one beat of
// o_seen_recently and o_outcome (recent hit, stale hit refreshed, inserted
// into a free slot, replaced the oldest slot) for every input beat.
// i_cfg_we / i_cfg_data write the rediscover window in milliseconds; it is
// only to be written while no beat is in flight.
// An accepted beat walks down a row of TABLE_ENTRIES cells, one cell per
// cycle; each cell registers the query. Its result is then loaded into the
// output register, and only after that can the next beat be taken, so the
// block handles one beat at a time.
// After reset the table is empty, the oldest-slot pointer is zero and the
// window is 10000 ms. If the receiver stalls, the finished result waits in
// the output register while the next beat is already taken and searched; its
// result waits in a pending register and the input stalls until it moves to the output.
module mac_rediscovery_filter
    import mrf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ADDR_W-1:0] i_mac_address,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_seen_recently,
    output logic [1:0]        o_outcome,
    input  logic              i_cfg_we,
    input  logic [WIN_W-1:0]  i_cfg_data
);

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);

    // Control and window registers.
    logic [WIN_W-1:0]  r_window;
    logic [CNT_W-1:0]  r_fill;
    logic [SLOT_W-1:0] r_oldest;
    logic              r_busy;
    logic              r_pend_valid;
    t_outcome          r_pend_outcome;
    logic              r_o_valid;
    t_outcome          r_o_outcome;

    t_token            w_tok [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_tok_valid;

    logic              w_accept;
    logic              w_exit;
    logic              w_full;
    logic              w_out_free;
    logic              w_load;
    logic [SLOT_W-1:0] w_slot;
    t_outcome          w_exit_outcome;

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    // The accepted beat enters the first cell directly.
    assign w_tok[0] = '{valid: w_accept, found: 1'b0, recent: 1'b0,
                        addr: i_mac_address, now: i_now_ms};

    // Once the query leaves the last cell, a miss is written into the next
    // free slot, or over the oldest one when the table is full.
    assign w_exit     = w_tok[TABLE_ENTRIES].valid;
    assign w_full     = (r_fill == CNT_W'(TABLE_ENTRIES));
    assign w_slot     = w_full ? r_oldest : r_fill[SLOT_W-1:0];
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_load     = (r_pend_valid || w_exit) && w_out_free;

    always_comb begin
        if (w_tok[TABLE_ENTRIES].found) begin
            w_exit_outcome = w_tok[TABLE_ENTRIES].recent ? OC_RECENT : OC_REFRESH;
        end else begin
            w_exit_outcome = w_full ? OC_REPLACE : OC_INSERT;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            mrf_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_tok      (w_tok[gi]),
                .i_window   (r_window),
                .i_in_use   (CNT_W'(gi) < r_fill),
                .i_ins_en   (w_exit && !w_tok[TABLE_ENTRIES].found &&
                             (w_slot == SLOT_W'(gi))),
                .i_ins_addr (w_tok[TABLE_ENTRIES].addr),
                .i_ins_time (w_tok[TABLE_ENTRIES].now),
                .o_tok      (w_tok[gi+1])
            );
            assign w_tok_valid[gi] = w_tok[gi+1].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    // Fill count and FIFO replacement pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
        end else if (w_exit && !w_tok[TABLE_ENTRIES].found) begin
            if (w_full) begin
                r_oldest <= (r_oldest == SLOT_W'(TABLE_ENTRIES - 1)) ? '0
                                                                     : r_oldest + 1'b1;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // The block stays busy until the result has reached the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_exit && !w_out_free) begin
                r_pend_valid <= 1'b1;
            end else if (w_out_free) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            r_pend_outcome <= w_exit_outcome;
        end
        if (w_load) begin
            r_o_outcome <= r_pend_valid ? r_pend_outcome : w_exit_outcome;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_outcome       = r_o_outcome;
    assign o_seen_recently = (r_o_outcome == OC_RECENT);

`ifndef NO_ASSERTIONS
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one query in the cell row");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok_valid) |-> r_busy)
        else $error("query in flight while the input is open");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond the table size");

    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (r_oldest == '0))
        else $error("replacement pointer moved before the table was full");

    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_o_valid && r_busy))
        else $error("pending result without a waiting output beat");
`endif

endmodule
